[hdl/srma_pkg.sv]
// Package for the serial register access master.
// Holds widths, register indexes, reset values and the result record type.
// No dependencies.
package srma_pkg;

   localparam int unsigned FRAME_BITS   = 18;
   localparam int unsigned READ_BITS    = 8;
   localparam int unsigned POST_HALVES  = 3;
   localparam int unsigned FINAL_HALVES = 2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHIP_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_GAP    = 2'd2;

   localparam logic [2:0]  CHIP_ADDRESS_RST = 3'd6;
   localparam logic [15:0] HALF_PERIOD_RST  = 16'd500;
   localparam logic [7:0]  WRITE_GAP_RST    = 8'd200;

   typedef struct packed {
      logic       enable_pin;
      logic       clock_pin;
      logic       data_out_pin;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
   } result_type;

endpackage

[hdl/srma_seq.sv]
// Pin sequencer of the serial register access master: phase state and one
// step per accepted transfer. Depends on srma_pkg.
module srma_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                start_req,
   input  logic                operation,
   input  logic [3:0]          row,
   input  logic [7:0]          write_value,
   input  logic                data_in_pin,
   input  logic [2:0]          chip_address,
   input  logic [15:0]         half_period_ticks,
   input  logic [7:0]          write_gap_halves,
   output srma_pkg::result_type res
);
   import srma_pkg::*;

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_LEAD   = 4'd1;
   localparam logic [3:0] PH_BLO    = 4'd2;
   localparam logic [3:0] PH_BHI    = 4'd3;
   localparam logic [3:0] PH_TAIL   = 4'd4;
   localparam logic [3:0] PH_GAP    = 4'd5;
   localparam logic [3:0] PH_RENH   = 4'd6;
   localparam logic [3:0] PH_RPULSE = 4'd7;
   localparam logic [3:0] PH_RPOST  = 4'd8;
   localparam logic [3:0] PH_RELOW  = 4'd9;
   localparam logic [3:0] PH_RBHI   = 4'd10;
   localparam logic [3:0] PH_RBLO   = 4'd11;
   localparam logic [3:0] PH_RFINAL = 4'd12;

   logic [3:0]            phase_ff, phase_in;
   logic [15:0]           tick_ff, tick_in;
   logic [7:0]            bit_ff, bit_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [READ_BITS-1:0]  rshift_ff, rshift_in;
   logic                  is_read_ff, is_read_in;

   logic [15:0]           half;
   logic [FRAME_BITS-1:0] frame_sel;
   logic [8:0]            bit_next;
   logic                  finish;

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      frame_in   = frame_ff;
      rshift_in  = rshift_ff;
      is_read_in = is_read_ff;
      finish     = 1'b0;
      res        = '0;
      res.enable_pin = 1'b1;
      half = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;

      if (phase_ff == PH_IDLE && start_req) begin
         frame_in   = {chip_address, ~operation, 2'b00, row,
                       operation ? 8'h00 : write_value};
         is_read_in = operation;
         tick_in    = '0;
         bit_in     = '0;
         rshift_in  = '0;
         phase_in   = PH_LEAD;
      end

      frame_sel = frame_in >> bit_in[4:0];
      bit_next  = {1'b0, bit_in} + 9'd1;

      unique case (phase_in)
         PH_IDLE: begin
            res.enable_pin = 1'b1;
         end
         PH_BLO: begin
            res.enable_pin   = 1'b0;
            res.data_out_pin = frame_sel[0];
         end
         PH_BHI: begin
            res.enable_pin   = 1'b0;
            res.clock_pin    = 1'b1;
            res.data_out_pin = frame_sel[0];
         end
         PH_GAP, PH_RENH, PH_RPOST: begin
            res.enable_pin = 1'b1;
         end
         PH_RPULSE: begin
            res.enable_pin = 1'b1;
            res.clock_pin  = 1'b1;
         end
         PH_RBHI: begin
            res.enable_pin = 1'b0;
            res.clock_pin  = 1'b1;
         end
         default: begin
            res.enable_pin = 1'b0;
         end
      endcase

      if (phase_in != PH_IDLE) begin
         res.busy_res = 1'b1;
         if (({1'b0, tick_in} + 17'd1) < {1'b0, half}) begin
            tick_in = tick_in + 16'd1;
         end else begin
            tick_in = '0;
            unique case (phase_in)
               PH_LEAD: begin
                  phase_in = PH_BLO;
                  bit_in   = '0;
               end
               PH_BLO: phase_in = PH_BHI;
               PH_BHI: begin
                  if (bit_next >= 9'(FRAME_BITS)) begin
                     phase_in = PH_TAIL;
                     bit_in   = '0;
                  end else begin
                     bit_in   = bit_next[7:0];
                     phase_in = PH_BLO;
                  end
               end
               PH_TAIL: begin
                  if (is_read_in) begin
                     phase_in = PH_RENH;
                  end else if (write_gap_halves == 8'd0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_GAP;
                     bit_in   = '0;
                  end
               end
               PH_GAP: begin
                  if (bit_next >= {1'b0, write_gap_halves}) finish = 1'b1;
                  else bit_in = bit_next[7:0];
               end
               PH_RENH: phase_in = PH_RPULSE;
               PH_RPULSE: begin
                  phase_in = PH_RPOST;
                  bit_in   = '0;
               end
               PH_RPOST: begin
                  if (bit_next >= 9'(POST_HALVES)) phase_in = PH_RELOW;
                  else bit_in = bit_next[7:0];
               end
               PH_RELOW: begin
                  phase_in = PH_RBHI;
                  bit_in   = '0;
               end
               PH_RBHI: begin
                  if (!data_in_pin) rshift_in[bit_in[2:0]] = 1'b1;
                  phase_in = PH_RBLO;
               end
               PH_RBLO: begin
                  if (bit_next >= 9'(READ_BITS)) begin
                     phase_in = PH_RFINAL;
                     bit_in   = '0;
                  end else begin
                     bit_in   = bit_next[7:0];
                     phase_in = PH_RBHI;
                  end
               end
               PH_RFINAL: begin
                  if (bit_next >= 9'(FINAL_HALVES)) finish = 1'b1;
                  else bit_in = bit_next[7:0];
               end
               default: finish = 1'b1;
            endcase
            if (finish) begin
               res.done_res  = 1'b1;
               res.read_data = is_read_in ? rshift_in : 8'h00;
               phase_in      = PH_IDLE;
               bit_in        = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         bit_ff     <= '0;
         frame_ff   <= '0;
         rshift_ff  <= '0;
         is_read_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         frame_ff   <= frame_in;
         rshift_ff  <= rshift_in;
         is_read_ff <= is_read_in;
      end
   end

endmodule

[hdl/srma_obuf.sv]
// Two-entry result buffer (output register plus skid register) of the
// serial register access master. Depends on srma_pkg.
module srma_obuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  srma_pkg::result_type in_res,
   input  logic                 out_stall,
   output logic                 out_valid,
   output srma_pkg::result_type out_res,
   output logic                 full
);
   import srma_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       main_free;

   always_comb begin
      main_free     = !main_valid_ff || !out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_res;
            main_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_in       = in_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;
   assign full      = skid_valid_ff;

endmodule

[hdl/serial_register_access_master_top.sv]
// Top level of the serial register access master: configuration registers,
// pin sequencer and result buffer. Depends on srma_pkg, srma_seq, srma_obuf.
//
// Each request transfer is one system tick. On an idle tick a start request
// begins a register write or read, and the sequencer drives enable, clock
// and data levels for the serial pins. Every request transfer yields exactly
// one response transfer carrying the pin levels, busy, done and read data.
// Throughput is one transfer per cycle while req_stall is low. The response
// is registered into the output register or skid register on the edge that
// updates the sequencer state. The response side has an output register
// and a skid register, so requests keep flowing while a response waits;
// req_stall rises only when both are full and clears once rsp_stall drops.
// Configuration writes go through csr_wr_en, csr_index and csr_wr_data and
// take effect on the next tick. Reset is synchronous: the sequencer returns
// to idle, the registers take their default values (chip address 6, half
// period 500 ticks, write gap 200 halves) and the response buffer empties.
module serial_register_access_master_top
   import srma_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_start_req,
   input  logic                   req_operation,
   input  logic [3:0]             req_row,
   input  logic [7:0]             req_write_value,
   input  logic                   req_data_in_pin,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_enable_pin,
   output logic                   rsp_clock_pin,
   output logic                   rsp_data_out_pin,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic [7:0]             rsp_read_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);
   import srma_pkg::*;

   logic [2:0]  chip_ff;
   logic [15:0] half_ff;
   logic [7:0]  gap_ff;
   logic        req_take;
   logic        buf_full;
   result_type  step_res;
   result_type  out_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_ff <= CHIP_ADDRESS_RST;
         half_ff <= HALF_PERIOD_RST;
         gap_ff  <= WRITE_GAP_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHIP_ADDRESS: chip_ff <= csr_wr_data[2:0];
            CSR_HALF_PERIOD:  half_ff <= csr_wr_data[15:0];
            CSR_WRITE_GAP:    gap_ff  <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   assign req_stall = buf_full;
   assign req_take  = req_valid && !buf_full;

   srma_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .step_en           (req_take),
      .start_req         (req_start_req),
      .operation         (req_operation),
      .row               (req_row),
      .write_value       (req_write_value),
      .data_in_pin       (req_data_in_pin),
      .chip_address      (chip_ff),
      .half_period_ticks (half_ff),
      .write_gap_halves  (gap_ff),
      .res               (step_res)
   );

   srma_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_res    (step_res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_res   (out_res),
      .full      (buf_full)
   );

   assign rsp_enable_pin   = out_res.enable_pin;
   assign rsp_clock_pin    = out_res.clock_pin;
   assign rsp_data_out_pin = out_res.data_out_pin;
   assign rsp_busy_res     = out_res.busy_res;
   assign rsp_done_res     = out_res.done_res;
   assign rsp_read_data    = out_res.read_data;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      buf_full |-> rsp_valid)
      else $error("skid register holds a transfer while the output register is empty");

   a_done_is_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> rsp_busy_res)
      else $error("done reported outside an access");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res) |->
         (rsp_enable_pin && !rsp_clock_pin && !rsp_data_out_pin && rsp_read_data == 8'h00))
      else $error("pins not at idle levels while not busy");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (req_take && rsp_valid && rsp_stall) |=> buf_full)
      else $error("transfer accepted into a stalled buffer was not held");

endmodule

[verif/pin_sequence_checker.sv]
`timescale 1ns / 1ps
// Checker for the serial register access master: predicts the pin levels of every
// request transfer from the request and register write ports and compares each
// response transfer field by field. Depends on srma_pkg.
module pin_sequence_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_start_req,
   input  logic                             req_operation,
   input  logic [3:0]                       req_row,
   input  logic [7:0]                       req_write_value,
   input  logic                             req_data_in_pin,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_enable_pin,
   input  logic                             rsp_clock_pin,
   input  logic                             rsp_data_out_pin,
   input  logic                             rsp_busy_res,
   input  logic                             rsp_done_res,
   input  logic [7:0]                       rsp_read_data,
   input  logic                             csr_wr_en,
   input  logic [srma_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srma_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int unsigned                      mismatch_count,
   output int unsigned                      pending_ticks
);
   import srma_pkg::*;

   typedef enum logic [4:0] {
      SEQ_IDLE,
      SEQ_LEAD,
      SEQ_BIT_LOW,
      SEQ_BIT_HIGH,
      SEQ_TAIL,
      SEQ_GAP,
      SEQ_READ_ENABLE,
      SEQ_READ_PULSE,
      SEQ_READ_POST,
      SEQ_READ_LOW,
      SEQ_SAMPLE_HIGH,
      SEQ_SAMPLE_LOW,
      SEQ_FINAL
   } seq_phase_type;

   logic [2:0]            chip_addr_cfg;
   logic [15:0]           half_ticks_cfg;
   logic [7:0]            gap_halves_cfg;
   seq_phase_type         phase_now;
   int unsigned           tick_cnt;
   int unsigned           step_idx;
   logic [FRAME_BITS-1:0] frame_bits;
   logic [7:0]            sampled_bits;
   logic                  read_access;
   result_type            expected_pins[$];
   int unsigned           errors = 0;

   task automatic restore_defaults();
      chip_addr_cfg  = CHIP_ADDRESS_RST;
      half_ticks_cfg = HALF_PERIOD_RST;
      gap_halves_cfg = WRITE_GAP_RST;
      phase_now      = SEQ_IDLE;
      tick_cnt       = 0;
      step_idx       = 0;
      frame_bits     = '0;
      sampled_bits   = '0;
      read_access    = 1'b0;
   endtask

   // One system tick of the pin sequencer. Pins reflect the phase in effect
   // on this tick; the phase advances when the current half period runs out.
   task automatic advance_pin_sequence(input logic start, input logic op,
                                       input logic [3:0] row, input logic [7:0] value,
                                       input logic din, output result_type pins);
      int unsigned half;
      logic        finish;
      pins   = '0;
      half   = (half_ticks_cfg == 16'd0) ? 1 : half_ticks_cfg;
      finish = 1'b0;
      if (phase_now == SEQ_IDLE && start) begin
         frame_bits   = {chip_addr_cfg, ~op, 2'b00, row, op ? 8'h00 : value};
         read_access  = op;
         tick_cnt     = 0;
         step_idx     = 0;
         sampled_bits = '0;
         phase_now    = SEQ_LEAD;
      end
      case (phase_now)
         SEQ_IDLE: pins.enable_pin = 1'b1;
         SEQ_BIT_LOW: pins.data_out_pin = frame_bits[step_idx];
         SEQ_BIT_HIGH: begin
            pins.clock_pin    = 1'b1;
            pins.data_out_pin = frame_bits[step_idx];
         end
         SEQ_GAP, SEQ_READ_ENABLE, SEQ_READ_POST: pins.enable_pin = 1'b1;
         SEQ_READ_PULSE: begin
            pins.enable_pin = 1'b1;
            pins.clock_pin  = 1'b1;
         end
         SEQ_SAMPLE_HIGH: pins.clock_pin = 1'b1;
         default: ;
      endcase
      if (phase_now != SEQ_IDLE) begin
         pins.busy_res = 1'b1;
         if (tick_cnt + 1 < half) begin
            tick_cnt++;
         end else begin
            tick_cnt = 0;
            case (phase_now)
               SEQ_LEAD: begin
                  phase_now = SEQ_BIT_LOW;
                  step_idx  = 0;
               end
               SEQ_BIT_LOW: phase_now = SEQ_BIT_HIGH;
               SEQ_BIT_HIGH: begin
                  if (step_idx + 1 >= FRAME_BITS) begin
                     phase_now = SEQ_TAIL;
                     step_idx  = 0;
                  end else begin
                     step_idx++;
                     phase_now = SEQ_BIT_LOW;
                  end
               end
               SEQ_TAIL: begin
                  if (read_access) begin
                     phase_now = SEQ_READ_ENABLE;
                  end else if (gap_halves_cfg == 8'd0) begin
                     finish = 1'b1;
                  end else begin
                     phase_now = SEQ_GAP;
                     step_idx  = 0;
                  end
               end
               SEQ_GAP: begin
                  if (step_idx + 1 >= gap_halves_cfg) finish = 1'b1;
                  else step_idx++;
               end
               SEQ_READ_ENABLE: phase_now = SEQ_READ_PULSE;
               SEQ_READ_PULSE: begin
                  phase_now = SEQ_READ_POST;
                  step_idx  = 0;
               end
               SEQ_READ_POST: begin
                  if (step_idx + 1 >= POST_HALVES) phase_now = SEQ_READ_LOW;
                  else step_idx++;
               end
               SEQ_READ_LOW: begin
                  phase_now = SEQ_SAMPLE_HIGH;
                  step_idx  = 0;
               end
               SEQ_SAMPLE_HIGH: begin
                  // The chip drives inverted data, so a low line stores a one.
                  if (!din) sampled_bits[step_idx] = 1'b1;
                  phase_now = SEQ_SAMPLE_LOW;
               end
               SEQ_SAMPLE_LOW: begin
                  if (step_idx + 1 >= READ_BITS) begin
                     phase_now = SEQ_FINAL;
                     step_idx  = 0;
                  end else begin
                     step_idx++;
                     phase_now = SEQ_SAMPLE_HIGH;
                  end
               end
               SEQ_FINAL: begin
                  if (step_idx + 1 >= FINAL_HALVES) finish = 1'b1;
                  else step_idx++;
               end
               default: finish = 1'b1;
            endcase
            if (finish) begin
               pins.done_res  = 1'b1;
               pins.read_data = read_access ? sampled_bits : 8'h00;
               phase_now      = SEQ_IDLE;
               step_idx       = 0;
            end
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : track
      result_type predicted;
      result_type observed;
      if (reset) begin
         restore_defaults();
         expected_pins.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHIP_ADDRESS: chip_addr_cfg = csr_wr_data[2:0];
               CSR_HALF_PERIOD: half_ticks_cfg = csr_wr_data;
               CSR_WRITE_GAP: gap_halves_cfg = csr_wr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_pin_sequence(req_start_req, req_operation, req_row, req_write_value,
                                 req_data_in_pin, predicted);
            expected_pins.insert(expected_pins.size(), predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            observed.enable_pin   = rsp_enable_pin;
            observed.clock_pin    = rsp_clock_pin;
            observed.data_out_pin = rsp_data_out_pin;
            observed.busy_res     = rsp_busy_res;
            observed.done_res     = rsp_done_res;
            observed.read_data    = rsp_read_data;
            if (expected_pins.size() == 0) begin
               $display("%0t: response transfer with nothing expected, expected none, actual %h",
                        $time, observed);
               errors++;
            end else begin
               predicted = expected_pins.pop_front();
               compare_field("enable_pin", 8'(predicted.enable_pin),
                             8'(observed.enable_pin));
               compare_field("clock_pin", 8'(predicted.clock_pin), 8'(observed.clock_pin));
               compare_field("data_out_pin", 8'(predicted.data_out_pin),
                             8'(observed.data_out_pin));
               compare_field("busy_res", 8'(predicted.busy_res), 8'(observed.busy_res));
               compare_field("done_res", 8'(predicted.done_res), 8'(observed.done_res));
               compare_field("read_data", predicted.read_data, observed.read_data);
            end
         end
      end
      pending_ticks  <= expected_pins.size();
      mismatch_count <= errors;
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Top of the serial register access master testbench: clock, reset, request
// stimulus, register writes, response stalls and the verdict. Depends on srma_pkg,
// serial_register_access_master_top and pin_sequence_checker.
module testbench;
   import srma_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned TICKS_PER_PHASE = 58;
   localparam int unsigned QUIET_PHASES    = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum {DIN_LOW, DIN_HIGH, DIN_RANDOM} din_mode_type;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic                   req_start_req   = 1'b0;
   logic                   req_operation   = 1'b0;
   logic [3:0]             req_row         = '0;
   logic [7:0]             req_write_value = '0;
   logic                   req_data_in_pin = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic                   rsp_enable_pin;
   logic                   rsp_clock_pin;
   logic                   rsp_data_out_pin;
   logic                   rsp_busy_res;
   logic                   rsp_done_res;
   logic [7:0]             rsp_read_data;
   logic                   csr_wr_en       = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index       = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data     = '0;

   int unsigned mismatch_count;
   int unsigned pending_ticks;
   int unsigned cycle_count = 0;
   int unsigned stall_pct   = 0;
   int unsigned stall_left  = 0;
   int unsigned gap_pct     = 0;
   logic        quiet       = 1'b0;

   serial_register_access_master_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_req    (req_start_req),
      .req_operation    (req_operation),
      .req_row          (req_row),
      .req_write_value  (req_write_value),
      .req_data_in_pin  (req_data_in_pin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_enable_pin   (rsp_enable_pin),
      .rsp_clock_pin    (rsp_clock_pin),
      .rsp_data_out_pin (rsp_data_out_pin),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   pin_sequence_checker u_pin_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_req    (req_start_req),
      .req_operation    (req_operation),
      .req_row          (req_row),
      .req_write_value  (req_write_value),
      .req_data_in_pin  (req_data_in_pin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_enable_pin   (rsp_enable_pin),
      .rsp_clock_pin    (rsp_clock_pin),
      .rsp_data_out_pin (rsp_data_out_pin),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .pending_ticks    (pending_ticks)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[7:0] == 8'd0) begin
         case ($urandom_range(2))
            0: stall_pct <= 0;
            1: stall_pct <= 15;
            default: stall_pct <= 40;
         endcase
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Response stalls come in bursts; none are raised during reset or quiet phases.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(5, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offers one system tick and returns at the edge where the transfer happens.
   task automatic send_tick(input logic start, input logic op, input logic [3:0] row,
                            input logic [7:0] value, input logic din);
      if (!quiet && $urandom_range(99) < gap_pct) pause_sender($urandom_range(6, 1));
      req_valid       <= 1'b1;
      req_start_req   <= start;
      req_operation   <= op;
      req_row         <= row;
      req_write_value <= value;
      req_data_in_pin <= din;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic run_ticks(input int unsigned count, input din_mode_type mode);
      int unsigned i;
      logic        din;
      for (i = 0; i < count; i++) begin
         case (mode)
            DIN_LOW: din = 1'b0;
            DIN_HIGH: din = 1'b1;
            default: din = 1'($urandom());
         endcase
         send_tick(1'b0, 1'($urandom()), 4'($urandom()), 8'($urandom()), din);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_ticks != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned phase_idx;
      int unsigned tick_idx;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gap_pct = 20;

      // Reset configuration, then a shorter half period and no write gap
      // applied while the access is already running.
      send_tick(1'b1, OP_WRITE, 4'hF, 8'hFF, 1'b0);
      send_tick(1'b1, OP_READ, 4'h3, 8'h00, 1'b1);
      send_tick(1'b1, OP_WRITE, 4'hC, 8'h81, 1'b0);
      run_ticks(18, DIN_RANDOM);
      settle();
      write_reg(CSR_HALF_PERIOD, 16'd1);
      write_reg(CSR_WRITE_GAP, 16'd0);
      run_ticks(60, DIN_RANDOM);

      settle();
      write_reg(CSR_CHIP_ADDRESS, 16'hFFF8);
      send_tick(1'b1, OP_WRITE, 4'h0, 8'h00, 1'b1);
      run_ticks(50, DIN_RANDOM);

      settle();
      write_reg(CSR_CHIP_ADDRESS, 16'd7);
      send_tick(1'b1, OP_READ, 4'hF, 8'hFF, 1'b0);
      run_ticks(70, DIN_LOW);
      send_tick(1'b1, OP_READ, 4'h0, 8'h00, 1'b1);
      run_ticks(70, DIN_HIGH);
      send_tick(1'b1, OP_READ, 4'h5, 8'h96, 1'b0);
      run_ticks(70, DIN_RANDOM);

      // A zero half period runs as one tick; the longest write gap.
      settle();
      write_reg(CSR_HALF_PERIOD, 16'd0);
      write_reg(CSR_WRITE_GAP, 16'hFFFF);
      send_tick(1'b1, OP_WRITE, 4'hA, 8'h5A, 1'b0);
      run_ticks(300, DIN_RANDOM);

      settle();
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      write_reg(CSR_WRITE_GAP, 16'd1);
      send_tick(1'b1, OP_WRITE, 4'h3, 8'hA5, 1'b1);
      run_ticks(50, DIN_RANDOM);

      // Longest half period, cut short by a register write mid access.
      settle();
      write_reg(CSR_HALF_PERIOD, 16'hFFFF);
      send_tick(1'b1, OP_READ, 4'h9, 8'h3C, 1'b0);
      run_ticks(150, DIN_RANDOM);
      settle();
      write_reg(CSR_HALF_PERIOD, 16'd2);
      write_reg(CSR_WRITE_GAP, 16'd3);
      run_ticks(140, DIN_RANDOM);

      for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         settle();
         if ($urandom_range(2) != 0) write_reg(CSR_CHIP_ADDRESS, 16'($urandom()));
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(9))
               0: write_reg(CSR_HALF_PERIOD, 16'd0);
               7, 8: write_reg(CSR_HALF_PERIOD, 16'd2);
               9: write_reg(CSR_HALF_PERIOD, 16'd3);
               default: write_reg(CSR_HALF_PERIOD, 16'd1);
            endcase
         end
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(2))
               0: write_reg(CSR_WRITE_GAP, {8'($urandom()), 8'd0});
               1: write_reg(CSR_WRITE_GAP, {8'($urandom()), 8'($urandom_range(6, 1))});
               default: write_reg(CSR_WRITE_GAP, {8'($urandom()), 8'($urandom_range(40))});
            endcase
         end
         case ($urandom_range(2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 35;
         endcase
         if (phase_idx >= RANDOM_PHASES - QUIET_PHASES) quiet <= 1'b1;
         for (tick_idx = 0; tick_idx < TICKS_PER_PHASE; tick_idx++) begin
            send_tick($urandom_range(3) == 0, 1'($urandom()), 4'($urandom()),
                      8'($urandom()), 1'($urandom()));
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
